@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file, ftba_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked in the same cycle
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/ftba_pkg.sv @@
// Package for the file table block allocator: sizes, codes, transfer types.
// Depends on nothing.
`default_nettype none
package ftba_pkg;
    localparam int NUM_BLOCKS      = 128;
    localparam int NUM_ENTRIES     = 16;
    localparam int MAX_FILE_BLOCKS = 8;

    localparam int EW   = $clog2(NUM_ENTRIES);
    localparam int BAW  = $clog2(NUM_BLOCKS);
    localparam int KW   = $clog2(MAX_FILE_BLOCKS);
    localparam int BCW  = $clog2(NUM_BLOCKS + 1);
    localparam int KCW  = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int SAW  = EW + KW;
    localparam int SLOTS = NUM_ENTRIES * MAX_FILE_BLOCKS;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SIZE      = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_NO_ENTRY  = 3'd3;
    localparam logic [2:0] ST_NO_BLOCKS = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] file_name;
        logic [3:0]  file_size;
        logic [2:0]  block_index;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] entry_index;
        logic [6:0] block_number;
    } t_result;

    typedef struct packed {
        t_cmd_item item;
        logic      size_err;
        logic      bad_cmd;
    } t_queue_item;

    typedef struct packed {
        logic        valid;
        t_queue_item data;
    } t_queue_out;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_EVAL, S_CNT, S_ALLOC,
        S_DEL_RD, S_DEL_WR, S_LOC_RD, S_LOC_WR, S_RESP
    } t_state;
endpackage
`default_nettype wire

@@ rtl/ftba_front.sv @@
// Front end: accepts commands, flags size errors and unused codes, queues them.
// Depends on ftba_pkg.
`default_nettype none
module ftba_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  ftba_pkg::t_cmd_item   i_in_data,
    output logic                  o_in_stall,
    output ftba_pkg::t_queue_out  o_q,
    input  wire                   i_q_pop
);
    import ftba_pkg::*;

    t_queue_item r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    t_queue_item w_item;

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        w_item.item     = i_in_data;
        w_item.size_err = (i_in_data.cmd == CMD_CREATE) &&
                          (i_in_data.file_size > 4'(MAX_FILE_BLOCKS));
        w_item.bad_cmd  = !(i_in_data.cmd inside {CMD_CREATE, CMD_DELETE, CMD_LOCATE});
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.data  = r_mem[r_rd_ptr];
endmodule
`default_nettype wire

@@ rtl/ftba_back.sv @@
// Back end: sequencer over the file table, free map and block list memory.
// Depends on ftba_pkg.
`default_nettype none
module ftba_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ftba_pkg::t_queue_out  i_q,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    output ftba_pkg::t_result     o_out_data,
    input  wire                   i_out_stall
);
    import ftba_pkg::*;

    t_state r_state, n_state;

    logic [NUM_BLOCKS-1:0]  r_in_use;
    logic [NUM_ENTRIES-1:0] r_ent_valid;
    logic [63:0]            r_ent_name  [NUM_ENTRIES];
    logic [KCW-1:0]         r_ent_count [NUM_ENTRIES];
    logic [SLOTS-1:0]       r_slot_ok;
    logic [BAW-1:0]         r_list [SLOTS];
    logic [BAW-1:0]         r_rd_data;
    logic                   r_rd_ok;

    t_cmd_item      r_item;
    logic [EW-1:0]  r_e;
    logic [EW-1:0]  r_sel;
    logic           r_exists, r_hit;
    logic [BCW-1:0] r_b;
    logic [KCW-1:0] r_k;
    t_result        r_res;
    logic           r_out_valid;
    t_result        r_out;

    logic           pop, load_out, mem_we, mem_re;
    logic [SAW-1:0] wr_addr, rd_addr;
    logic           ent_match, ent_free, b_free, k_done, b_end;
    logic [KCW-1:0] size_k;

    assign size_k    = KCW'(r_item.file_size);
    assign ent_match = r_ent_valid[r_e] && (r_ent_name[r_e] == r_item.file_name);
    assign ent_free  = !r_ent_valid[r_e];
    assign b_free    = !r_in_use[r_b[BAW-1:0]];
    assign b_end     = (r_b == BCW'(NUM_BLOCKS));
    assign k_done    = (r_state == S_DEL_RD) ? (r_k == r_ent_count[r_sel]) : (r_k == size_k);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q.valid) begin
                n_state = (i_q.data.size_err || i_q.data.bad_cmd) ? S_RESP : S_SCAN;
            end
            S_SCAN: if (r_e == EW'(NUM_ENTRIES - 1)) n_state = S_EVAL;
            S_EVAL: begin
                if (r_item.cmd == CMD_CREATE) begin
                    n_state = (r_exists || !r_hit) ? S_RESP : S_CNT;
                end else if (!r_hit) begin
                    n_state = S_RESP;
                end else begin
                    n_state = (r_item.cmd == CMD_DELETE) ? S_DEL_RD : S_LOC_RD;
                end
            end
            S_CNT:    if (k_done) n_state = S_ALLOC; else if (b_end) n_state = S_RESP;
            S_ALLOC:  if (k_done) n_state = S_RESP;
            S_DEL_RD: n_state = k_done ? S_RESP : S_DEL_WR;
            S_DEL_WR: n_state = S_DEL_RD;
            S_LOC_RD: n_state = S_LOC_WR;
            S_LOC_WR: n_state = S_RESP;
            S_RESP:   if (!r_out_valid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop      = (r_state == S_IDLE) && i_q.valid;
        load_out = (r_state == S_RESP) && !r_out_valid;
        mem_we   = (r_state == S_ALLOC) && !k_done && b_free;
        mem_re   = ((r_state == S_DEL_RD) && !k_done) || (r_state == S_LOC_RD);
        wr_addr  = {r_sel, r_k[KW-1:0]};
        rd_addr  = (r_state == S_LOC_RD) ? {r_sel, r_item.block_index[KW-1:0]}
                                         : {r_sel, r_k[KW-1:0]};
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_list[wr_addr] <= r_b[BAW-1:0];
        if (mem_re) begin
            r_rd_data <= r_list[rd_addr];
            r_rd_ok   <= r_slot_ok[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_ent_valid <= '0;
            r_slot_ok   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (mem_we) begin
                r_in_use[r_b[BAW-1:0]] <= 1'b1;
                r_slot_ok[wr_addr]     <= 1'b1;
            end
            if (r_state == S_ALLOC && k_done) r_ent_valid[r_sel] <= 1'b1;
            if (r_state == S_DEL_RD && k_done) r_ent_valid[r_sel] <= 1'b0;
            if (r_state == S_DEL_WR) begin
                r_in_use[r_rd_ok ? r_rd_data : BAW'(0)] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item   <= i_q.data.item;
                r_e      <= '0;
                r_exists <= 1'b0;
                r_hit    <= 1'b0;
                r_sel    <= '0;
                r_b      <= '0;
                r_k      <= '0;
                r_res    <= '{status: i_q.data.size_err ? ST_SIZE : ST_NOT_FOUND,
                              entry_index: '0, block_number: '0};
            end
            S_SCAN: begin
                r_e <= r_e + EW'(1);
                if (r_item.cmd == CMD_CREATE) begin
                    if (ent_free) begin
                        r_sel <= r_e;
                        r_hit <= 1'b1;
                    end else if (ent_match) begin
                        r_exists <= 1'b1;
                    end
                end else if (ent_match && !r_hit) begin
                    r_sel <= r_e;
                    r_hit <= 1'b1;
                end
            end
            S_EVAL: begin
                if (r_item.cmd == CMD_CREATE) begin
                    if (r_exists) r_res.status <= ST_EXISTS;
                    else if (!r_hit) r_res.status <= ST_NO_ENTRY;
                end
            end
            S_CNT: begin
                if (k_done) begin
                    r_b <= '0;
                    r_k <= '0;
                end else if (b_end) begin
                    r_res.status <= ST_NO_BLOCKS;
                end else begin
                    if (b_free) r_k <= r_k + KCW'(1);
                    r_b <= r_b + BCW'(1);
                end
            end
            S_ALLOC: begin
                if (k_done) begin
                    r_ent_name[r_sel]  <= r_item.file_name;
                    r_ent_count[r_sel] <= size_k;
                    r_res.status       <= ST_OK;
                    r_res.entry_index  <= 4'(r_sel);
                end else begin
                    if (b_free) r_k <= r_k + KCW'(1);
                    r_b <= r_b + BCW'(1);
                end
            end
            S_DEL_RD: begin
                if (k_done) begin
                    r_res.status      <= ST_OK;
                    r_res.entry_index <= 4'(r_sel);
                end
            end
            S_DEL_WR: r_k <= r_k + KCW'(1);
            S_LOC_WR: begin
                r_res.status       <= ST_OK;
                r_res.entry_index  <= 4'(r_sel);
                r_res.block_number <= r_rd_ok ? 7'(r_rd_data) : 7'd0;
            end
            S_RESP: if (load_out) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ rtl/file_table_block_allocator_unit.sv @@
// File table with a bitmap block allocator: create, delete and locate commands.
// Top level; depends on ftba_pkg, ftba_front and ftba_back.
//
// Input channel i_in_valid/o_in_stall carries one command per transfer
// (cmd, file_name, file_size, block_index). A two-deep queue takes commands
// while the sequencer is busy; o_in_stall rises only when it is full.
// Output channel o_out_valid/i_out_stall gives one result per command
// (status, entry_index, block_number) from an output register, held while
// the receiver stalls.
// Commands run one at a time through the sequencer. Every command that gets
// past decode scans all entries, one per cycle.
// A size error or an unused code goes straight to the response step. A delete
// hit reads and frees its blocks one at a time; a locate hit reads one slot of
// the block list. A create makes two passes over the free map, one block per
// cycle, first counting free blocks and then taking them; each pass ends at the
// last free block needed. The free-map walk sets the create rate.
// Reset empties the table and the free map at once; no clearing pass.
// A stalled result holds the sequencer in the next command's response step.
`default_nettype none
module file_table_block_allocator_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  ftba_pkg::t_cmd_item  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output ftba_pkg::t_result    o_out_data,
    input  wire                  i_out_stall
);
    import ftba_pkg::*;

    t_queue_out q;
    logic       q_pop;

    ftba_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q        (q),
        .i_q_pop    (q_pop)
    );

    ftba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );
endmodule
`default_nettype wire

@@ rtl/ftba_checker.sv @@
// Port-level checks for the allocator top level, with its bind.
// Depends on ftba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ftba_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input ftba_pkg::t_result   o_out_data
);
    import ftba_pkg::*;

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `AST_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `AST_IMPL(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_data.status <= ST_NOT_FOUND)
    `AST_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_OK, o_out_data.entry_index == 4'd0 && o_out_data.block_number == 7'd0)
endmodule

bind file_table_block_allocator_unit ftba_checker u_ftba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for file_table_block_allocator_unit: directed and random create,
// delete and locate commands checked against an in-bench model of the table.
// Depends on ftba_pkg and the RTL top level.
`default_nettype none
module tb_top;
    import ftba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_cmd_item   i_in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_result     o_out_data;
    logic        i_out_stall = 1'b0;

    file_table_block_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // table model
    logic                 blk_used [NUM_BLOCKS];
    logic                 ent_valid [NUM_ENTRIES];
    logic [63:0]          ent_name [NUM_ENTRIES];
    logic [3:0]           ent_count [NUM_ENTRIES];
    logic [BAW-1:0]       ent_blocks [NUM_ENTRIES][MAX_FILE_BLOCKS];

    t_cmd_item   pending_cmds[$];
    t_result     expected_results[$];
    logic        pause_req = 1'b0;   // sender holds off while this is set
    logic        calm = 1'b0;        // no random input gaps or output stalls
    int          errors = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_ok = 0;
    int          idle_cycles = 0;
    logic [63:0] name_pool [8];

    function automatic t_result apply_command(t_cmd_item c);
        t_result r;
        int free_e, hit, found, k;
        logic exists;
        r = '0;
        r.status = ST_NOT_FOUND;
        hit = -1;
        for (int e = 0; e < NUM_ENTRIES; e++)
            if (hit < 0 && ent_valid[e] && ent_name[e] == c.file_name) hit = e;
        case (c.cmd)
            CMD_CREATE: begin
                free_e = -1;
                exists = 1'b0;
                if (c.file_size > MAX_FILE_BLOCKS) begin
                    r.status = ST_SIZE;
                end else begin
                    for (int e = 0; e < NUM_ENTRIES; e++) begin
                        if (!ent_valid[e]) free_e = e;
                        else if (ent_name[e] == c.file_name) exists = 1'b1;
                    end
                    found = 0;
                    for (int b = 0; b < NUM_BLOCKS; b++) if (!blk_used[b]) found++;
                    if (exists) r.status = ST_EXISTS;
                    else if (free_e < 0) r.status = ST_NO_ENTRY;
                    else if (found < c.file_size) r.status = ST_NO_BLOCKS;
                    else begin
                        k = 0;
                        for (int b = 0; b < NUM_BLOCKS; b++) begin
                            if (k < c.file_size && !blk_used[b]) begin
                                blk_used[b] = 1'b1;
                                ent_blocks[free_e][k] = BAW'(b);
                                k++;
                            end
                        end
                        ent_valid[free_e] = 1'b1;
                        ent_name[free_e] = c.file_name;
                        ent_count[free_e] = c.file_size;
                        r.status = ST_OK;
                        r.entry_index = 4'(free_e);
                    end
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) begin
                    for (int j = 0; j < MAX_FILE_BLOCKS; j++)
                        if (j < ent_count[hit]) blk_used[ent_blocks[hit][j]] = 1'b0;
                    ent_valid[hit] = 1'b0;
                    r.status = ST_OK;
                    r.entry_index = 4'(hit);
                end
            end
            CMD_LOCATE: begin
                if (hit >= 0) begin
                    r.status = ST_OK;
                    r.entry_index = 4'(hit);
                    r.block_number = ent_blocks[hit][c.block_index % MAX_FILE_BLOCKS];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_stall)) begin
            if (pending_cmds.size() > 0 && !pause_req
                    && (calm || $urandom_range(99) >= 11)) begin
                i_in_data <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
                i_in_data <= '0;
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 11);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_command(i_in_data));
                n_sent <= n_sent + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                n_recv <= n_recv + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d", o_out_data.status);
                    errors = errors + 1;
                end else begin
                    t_result x;
                    x = expected_results.pop_front();
                    if (x.status == ST_OK) n_ok <= n_ok + 1;
                    if (x.status != o_out_data.status) begin
                        $error("status exp %0d got %0d", x.status, o_out_data.status);
                        errors = errors + 1;
                    end
                    if (x.entry_index != o_out_data.entry_index) begin
                        $error("entry_index exp %0d got %0d", x.entry_index,
                               o_out_data.entry_index);
                        errors = errors + 1;
                    end
                    if (x.block_number != o_out_data.block_number) begin
                        $error("block_number exp %0d got %0d", x.block_number,
                               o_out_data.block_number);
                        errors = errors + 1;
                    end
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic t_cmd_item mk(logic [1:0] c, logic [63:0] n, logic [3:0] s,
                                     logic [2:0] bi);
        t_cmd_item t;
        t.cmd = c; t.file_name = n; t.file_size = s; t.block_index = bi;
        return t;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_cmd_item t;
        for (int b = 0; b < NUM_BLOCKS; b++) blk_used[b] = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            ent_valid[e] = 1'b0;
            ent_name[e] = '0;
            ent_count[e] = '0;
            for (int j = 0; j < MAX_FILE_BLOCKS; j++) ent_blocks[e][j] = '0;
        end
        for (int i = 0; i < 8; i++) name_pool[i] = {$urandom(), $urandom()};
        name_pool[0] = 64'h0;
        name_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        name_pool[2] = 64'h6100_0000_0000_0000;

        // directed
        pending_cmds.push_back(mk(CMD_LOCATE, name_pool[2], 4'd0, 3'd7));
        pending_cmds.push_back(mk(CMD_DELETE, name_pool[2], 4'd0, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[2], 4'd15, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[2], 4'd9, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[2], 4'd8, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[2], 4'd1, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[0], 4'd0, 3'd0));
        pending_cmds.push_back(mk(CMD_LOCATE, name_pool[0], 4'd0, 3'd5));
        pending_cmds.push_back(mk(CMD_LOCATE, name_pool[2], 4'd0, 3'd7));
        pending_cmds.push_back(mk(CMD_CREATE, name_pool[1], 4'd3, 3'd0));
        pending_cmds.push_back(mk(2'd3, name_pool[1], 4'd15, 3'd7));
        pending_cmds.push_back(mk(CMD_DELETE, name_pool[2], 4'd0, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, 64'h7A7A, 4'd2, 3'd0));
        pending_cmds.push_back(mk(CMD_LOCATE, 64'h7A7A, 4'd0, 3'd6));
        // fill the table past full, so the last two creates find no free entry
        for (int i = 0; i < 14; i++)
            pending_cmds.push_back(mk(CMD_CREATE, 64'h100 + i, 4'd8, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, 64'h200, 4'd0, 3'd0));
        pending_cmds.push_back(mk(CMD_DELETE, 64'h100, 4'd0, 3'd0));
        pending_cmds.push_back(mk(CMD_CREATE, 64'h201, 4'd8, 3'd0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        pause_req = 1'b1;
        repeat (5) @(posedge i_clk);
        pause_req = 1'b0;

        // random phase: names from a small pool so hits are common
        for (int i = 0; i < 400; i++) begin
            int r;
            r = $urandom_range(99);
            if (r < 3) t.cmd = 2'd3;
            else if (r < 40) t.cmd = CMD_CREATE;
            else if (r < 65) t.cmd = CMD_DELETE;
            else t.cmd = CMD_LOCATE;
            t.file_name = ($urandom_range(9) == 0) ? {$urandom(), $urandom()}
                                                   : name_pool[$urandom_range(7)];
            t.file_size = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(8));
            t.block_index = 3'($urandom_range(7));
            pending_cmds.push_back(t);
            if (i == 150) begin
                wait_drained();
                calm = 1'b1;
            end
            if (i == 250) begin
                wait_drained();
                calm = 1'b0;
            end
        end
        wait_drained();
        repeat (300) @(posedge i_clk);

        $display("ran %0d commands (%0d ok) through create/delete/locate, random stalls",
                 n_sent, n_ok);
        if (errors == 0 && expected_results.size() == 0 && n_recv == n_sent)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
